>>> sv/lcsa_pkg.sv
// Shared types and constants of the layered column span accumulator.
package lcsa_pkg;

   localparam int SCREEN_COLUMNS = 1024;
   localparam int MAX_LAYERS     = 8;
   localparam int COL_BITS       = $clog2(SCREEN_COLUMNS);
   localparam int LAYER_BITS     = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int ADDR_BITS      = LAYER_BITS + COL_BITS;
   localparam int MEM_DEPTH      = MAX_LAYERS * SCREEN_COLUMNS;

   localparam int RESET_VIEW_WIDTH  = 320;
   localparam int RESET_VIEW_HEIGHT = 200;

   localparam logic [1:0] CSR_VIEW_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_VIEW_HEIGHT = 2'd1;

   localparam logic [2:0] RSP_PLACED   = 3'd0;
   localparam logic [2:0] RSP_IGNORED  = 3'd1;
   localparam logic [2:0] RSP_OVERFLOW = 3'd2;
   localparam logic [2:0] RSP_READ     = 3'd3;
   localparam logic [2:0] RSP_CLEARED  = 3'd4;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_LOOKUP,
      S_DECIDE,
      S_CLEAR,
      S_CLEAR_RSP
   } state_type;

   typedef struct packed {
      logic start;        // capture request fields
      logic sweep_start;  // begin a clear: capture clear values, empty ranges
      logic sweep_en;     // write one cleared entry
      logic rd_en;        // read the entry of the current layer
      logic layer_inc;    // descend one layer
      logic rsp_load;     // commit update and load result register
   } ctl_cmd_type;

   typedef struct packed {
      logic req_clear;
      logic sweep_last;
      logic descend;
   } dp_stat_type;

endpackage

>>> sv/layered_column_span_accumulator_core.sv
// Layered column span accumulator: span memory of all layers with its controller.
// The block keeps 8 layers of 1024 column openings in one single-port span memory
// and takes one transfer at a time. An add reads the memory (lookup) and compares
// (decide) once for each layer visited and commits in its last decide; a read,
// an ignored add or the unused action visits one layer. A clear rewrites all 8192
// memory entries, one a cycle, then commits its result; after reset the same
// pass runs before the first transfer is accepted, while register writes are taken
// at any time. A finished result waits in an output register, so the next item is
// accepted while it is held; that item then stalls until the result is taken.
module layered_column_span_accumulator_core
   import lcsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [9:0]         req_column,
   input  logic signed [11:0] req_span_top,
   input  logic signed [11:0] req_span_bottom,
   input  logic [2:0]         req_read_layer,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [2:0]         rsp_layer,
   output logic signed [11:0] rsp_out_top,
   output logic signed [11:0] rsp_out_bottom,
   output logic [10:0]        rsp_range_min,
   output logic [10:0]        rsp_range_max
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   lcsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lcsa_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_action      (req_action),
      .req_column      (req_column),
      .req_span_top    (req_span_top),
      .req_span_bottom (req_span_bottom),
      .req_read_layer  (req_read_layer),
      .rsp_status      (rsp_status),
      .rsp_layer       (rsp_layer),
      .rsp_out_top     (rsp_out_top),
      .rsp_out_bottom  (rsp_out_bottom),
      .rsp_range_min   (rsp_range_min),
      .rsp_range_max   (rsp_range_max)
   );

   // a held result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || rsp_ready))
      else $error("result register loaded while a result is pending");

   // no transfer is taken while the memory is being cleared
   assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_en |-> !req_ready)
      else $error("request accepted during clear pass");

   // a result appears only after the controller commits one
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.rsp_load))
      else $error("result valid without a load");

   // descending and committing never happen together
   assert property (@(posedge clock) disable iff (reset)
      cmd.layer_inc |-> !cmd.rsp_load && !cmd.rd_en)
      else $error("layer step overlaps commit or read");

endmodule

>>> sv/lcsa_ctrl.sv
// Controller state machine of the layered column span accumulator.
module lcsa_ctrl
   import lcsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (stat.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = stat.req_clear ? S_CLEAR : S_LOOKUP;
         end
         S_LOOKUP: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.descend) state_in = S_LOOKUP;
            else if (out_free) state_in = S_IDLE;
         end
         S_CLEAR: begin
            if (stat.sweep_last) state_in = S_CLEAR_RSP;
         end
         S_CLEAR_RSP: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.sweep_en = 1'b1;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start       = 1'b1;
               cmd.sweep_start = stat.req_clear;
            end
         end
         S_LOOKUP: begin
            cmd.rd_en = 1'b1;
         end
         S_DECIDE: begin
            if (stat.descend) cmd.layer_inc = 1'b1;
            else cmd.rsp_load = out_free;
         end
         S_CLEAR: begin
            cmd.sweep_en = 1'b1;
         end
         S_CLEAR_RSP: begin
            cmd.rsp_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> sv/lcsa_datapath.sv
// Datapath: span memory, layer ranges, view registers and result register.
module lcsa_datapath
   import lcsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctl_cmd_type        cmd,
   output dp_stat_type        stat,
   input  logic               csr_valid,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_wdata,
   input  logic [1:0]         req_action,
   input  logic [9:0]         req_column,
   input  logic signed [11:0] req_span_top,
   input  logic signed [11:0] req_span_bottom,
   input  logic [2:0]         req_read_layer,
   output logic [2:0]         rsp_status,
   output logic [2:0]         rsp_layer,
   output logic signed [11:0] rsp_out_top,
   output logic signed [11:0] rsp_out_bottom,
   output logic [10:0]        rsp_range_min,
   output logic [10:0]        rsp_range_max
);

   logic [10:0] view_width_ff, view_height_ff;

   action_type               act_ff;
   logic [9:0]               col_ff;
   logic signed [11:0]       ytop_ff, ybot_ff;
   logic [LAYER_BITS-1:0]    layer_ff;
   logic                     layer_ok_ff;
   logic signed [11:0]       clr_top_ff;
   logic [ADDR_BITS-1:0]     sweep_ff;
   logic signed [11:0]       rd_top_ff, rd_bot_ff;
   logic [10:0]              min_ff [MAX_LAYERS];
   logic [10:0]              max_ff [MAX_LAYERS];
   logic [23:0]              mem [MEM_DEPTH];

   logic [2:0]         status_ff;
   logic [2:0]         olayer_ff;
   logic signed [11:0] otop_ff, obot_ff;
   logic [10:0]        omin_ff, omax_ff;

   logic [ADDR_BITS-1:0] addr;
   logic                 col_ok, offscr, live, pass, place, last, in_range, empty, disjoint;
   logic signed [12:0]   ytop_x, vh_x;
   logic [10:0]          col_x, cur_min, cur_max, new_min, new_max;
   logic signed [11:0]   cur_top, cur_bot, new_top, new_bot;
   logic [2:0]           status_in, olayer_in;
   logic signed [11:0]   otop_in, obot_in;
   logic [10:0]          omin_in, omax_in;

   assign addr   = {layer_ff, col_ff[COL_BITS-1:0]};
   assign col_x  = {1'b0, col_ff};
   assign col_ok = int'(col_ff) < SCREEN_COLUMNS;
   assign ytop_x = {ytop_ff[11], ytop_ff};
   assign vh_x   = $signed({2'b00, view_height_ff});

   assign cur_min = layer_ok_ff ? min_ff[layer_ff] : view_width_ff;
   assign cur_max = layer_ok_ff ? max_ff[layer_ff] : 11'd0;
   assign cur_top = (layer_ok_ff && col_ok) ? rd_top_ff : $signed({1'b0, view_height_ff});
   assign cur_bot = (layer_ok_ff && col_ok) ? rd_bot_ff : -12'sd1;

   assign offscr   = (ybot_ff <= 12'sd0) || (ytop_x >= vh_x) || !col_ok;
   assign in_range = (col_x <= cur_max) && (col_x >= cur_min);
   assign empty    = rd_top_ff > rd_bot_ff;
   assign disjoint = (ytop_ff >= rd_bot_ff) || (ybot_ff <= rd_top_ff);
   assign live     = (act_ff == ACT_ADD) && !offscr;
   assign pass     = live && in_range && !empty && disjoint;
   assign place    = live && !pass;
   assign last     = layer_ff == LAYER_BITS'(MAX_LAYERS - 1);

   assign stat.descend    = pass && !last;
   assign stat.sweep_last = sweep_ff == ADDR_BITS'(MEM_DEPTH - 1);
   assign stat.req_clear  = req_action == ACT_CLEAR;

   // Merge into an occupied opening, otherwise the span is stored as given.
   always_comb begin
      new_top = ytop_ff;
      new_bot = ybot_ff;
      if (in_range && !empty) begin
         if (rd_top_ff < ytop_ff) new_top = rd_top_ff;
         if (rd_bot_ff > ybot_ff) new_bot = rd_bot_ff;
      end
   end

   always_comb begin
      new_min = cur_min;
      new_max = cur_max;
      if (!in_range) begin
         priority if (cur_max < cur_min) begin
            new_min = col_x;
            new_max = col_x;
         end else if (col_x > cur_max) begin
            new_max = col_x;
         end else begin
            new_min = col_x;
         end
      end
   end

   always_comb begin
      status_in = RSP_IGNORED;
      olayer_in = 3'(layer_ff);
      otop_in   = cur_top;
      obot_in   = cur_bot;
      omin_in   = cur_min;
      omax_in   = cur_max;
      unique case (act_ff)
         ACT_CLEAR: begin
            status_in = RSP_CLEARED;
            otop_in   = col_ok ? clr_top_ff : $signed({1'b0, view_height_ff});
            obot_in   = -12'sd1;
         end
         ACT_READ: begin
            status_in = RSP_READ;
         end
         ACT_NONE: begin
            status_in = RSP_IGNORED;
            olayer_in = 3'd0;
            otop_in   = '0;
            obot_in   = '0;
            omin_in   = '0;
            omax_in   = '0;
         end
         ACT_ADD: begin
            priority if (offscr) begin
               status_in = RSP_IGNORED;
            end else if (pass) begin
               status_in = RSP_OVERFLOW;
            end else begin
               status_in = RSP_PLACED;
               otop_in   = new_top;
               obot_in   = new_bot;
               omin_in   = new_min;
               omax_in   = new_max;
            end
         end
         default: status_in = RSP_IGNORED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         view_width_ff  <= 11'(RESET_VIEW_WIDTH);
         view_height_ff <= 11'(RESET_VIEW_HEIGHT);
      end else if (csr_valid) begin
         if (csr_index == CSR_VIEW_WIDTH) view_width_ff <= csr_wdata;
         if (csr_index == CSR_VIEW_HEIGHT) view_height_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_top_ff <= 12'(RESET_VIEW_HEIGHT);
         sweep_ff   <= '0;
      end else if (cmd.sweep_start) begin
         clr_top_ff <= $signed({1'b0, view_height_ff});
         sweep_ff   <= '0;
      end else if (cmd.sweep_en) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LAYERS; i++) begin
            min_ff[i] <= 11'(RESET_VIEW_WIDTH);
            max_ff[i] <= '0;
         end
      end else if (cmd.sweep_start) begin
         for (int i = 0; i < MAX_LAYERS; i++) begin
            min_ff[i] <= view_width_ff;
            max_ff[i] <= '0;
         end
      end else if (cmd.rsp_load && place) begin
         min_ff[layer_ff] <= new_min;
         max_ff[layer_ff] <= new_max;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         act_ff      <= action_type'(req_action);
         col_ff      <= req_column;
         ytop_ff     <= req_span_top;
         ybot_ff     <= req_span_bottom;
         layer_ff    <= (req_action == ACT_READ) ? req_read_layer[LAYER_BITS-1:0] : '0;
         layer_ok_ff <= (req_action != ACT_READ) || (int'(req_read_layer) < MAX_LAYERS);
      end else if (cmd.layer_inc) begin
         layer_ff <= layer_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_en) mem[sweep_ff] <= {clr_top_ff, -12'sd1};
      else if (cmd.rsp_load && place) mem[addr] <= {new_top, new_bot};
      if (cmd.rd_en) {rd_top_ff, rd_bot_ff} <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         status_ff <= status_in;
         olayer_ff <= olayer_in;
         otop_ff   <= otop_in;
         obot_ff   <= obot_in;
         omin_ff   <= omin_in;
         omax_ff   <= omax_in;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_layer      = olayer_ff;
   assign rsp_out_top    = otop_ff;
   assign rsp_out_bottom = obot_ff;
   assign rsp_range_min  = omin_ff;
   assign rsp_range_max  = omax_ff;

endmodule

>>> sim/tb_layered_column_span_accumulator_core.sv
// Self-checking testbench of the layered column span accumulator core.
`timescale 1ns / 100ps

module tb_layered_column_span_accumulator_core;
   import lcsa_pkg::*;

   // csr indexes that map to no register
   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;

   typedef struct {
      action_type        action;
      logic [9:0]        column;
      logic signed [11:0] top;
      logic signed [11:0] bottom;
      logic [2:0]        rlayer;
   } span_req_type;

   typedef struct {
      logic [2:0]         status;
      logic [2:0]         layer;
      logic signed [11:0] top;
      logic signed [11:0] bottom;
      logic [10:0]        rmin;
      logic [10:0]        rmax;
   } col_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [10:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = '0;
   logic [9:0]         req_column = '0;
   logic signed [11:0] req_span_top = '0;
   logic signed [11:0] req_span_bottom = '0;
   logic [2:0]         req_read_layer = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic [2:0]         rsp_layer;
   logic signed [11:0] rsp_out_top;
   logic signed [11:0] rsp_out_bottom;
   logic [10:0]        rsp_range_min;
   logic [10:0]        rsp_range_max;

   layered_column_span_accumulator_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_column      (req_column),
      .req_span_top    (req_span_top),
      .req_span_bottom (req_span_bottom),
      .req_read_layer  (req_read_layer),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_layer       (rsp_layer),
      .rsp_out_top     (rsp_out_top),
      .rsp_out_bottom  (rsp_out_bottom),
      .rsp_range_min   (rsp_range_min),
      .rsp_range_max   (rsp_range_max)
   );

   always #5 clock = ~clock;

   // ---------------- layer model ----------------
   logic signed [11:0] open_top [MAX_LAYERS][SCREEN_COLUMNS];
   logic signed [11:0] open_bot [MAX_LAYERS][SCREEN_COLUMNS];
   logic [10:0]        used_min [MAX_LAYERS];
   logic [10:0]        used_max [MAX_LAYERS];
   logic [10:0]        cfg_view_width;
   logic [10:0]        cfg_view_height;

   function automatic void wipe_layers();
      for (int l = 0; l < MAX_LAYERS; l++) begin
         for (int c = 0; c < SCREEN_COLUMNS; c++) begin
            open_top[l][c] = 12'(cfg_view_height);
            open_bot[l][c] = -12'sd1;
         end
         used_min[l] = cfg_view_width;
         used_max[l] = '0;
      end
   endfunction

   function automatic col_result_type column_report(logic [2:0] status, int lyr, int col);
      col_result_type res;
      res.status = status;
      res.layer  = 3'(lyr);
      res.top    = open_top[lyr][col];
      res.bottom = open_bot[lyr][col];
      res.rmin   = used_min[lyr];
      res.rmax   = used_max[lyr];
      return res;
   endfunction

   function automatic col_result_type apply_request(span_req_type r);
      int col, ytop, ybot, vh, pt, pb, mn, mx;
      col_result_type res;
      col  = r.column;
      ytop = r.top;
      ybot = r.bottom;
      vh   = cfg_view_height;
      case (r.action)
         ACT_CLEAR: begin
            wipe_layers();
            return column_report(RSP_CLEARED, 0, col);
         end
         ACT_READ: return column_report(RSP_READ, r.rlayer, col);
         ACT_NONE: begin
            res = '{default: '0};
            res.status = RSP_IGNORED;
            return res;
         end
         default: ;
      endcase
      if (ybot <= 0 || ytop >= vh)
         return column_report(RSP_IGNORED, 0, col);
      for (int lyr = 0; lyr < MAX_LAYERS; lyr++) begin
         pt = open_top[lyr][col];
         pb = open_bot[lyr][col];
         mn = used_min[lyr];
         mx = used_max[lyr];
         if (col <= mx && col >= mn) begin
            if (pt > pb) begin
               open_top[lyr][col] = 12'(ytop);
               open_bot[lyr][col] = 12'(ybot);
            end else if (ytop >= pb || ybot <= pt) begin
               continue;  // disjoint (touching counts): try the next layer
            end else begin
               if (ytop < pt) open_top[lyr][col] = 12'(ytop);
               if (ybot > pb) open_bot[lyr][col] = 12'(ybot);
            end
         end else begin
            if (mx < mn) begin
               used_min[lyr] = 11'(col);
               used_max[lyr] = 11'(col);
            end else if (col > mx) begin
               used_max[lyr] = 11'(col);
            end else begin
               used_min[lyr] = 11'(col);
            end
            open_top[lyr][col] = 12'(ytop);
            open_bot[lyr][col] = 12'(ybot);
         end
         return column_report(RSP_PLACED, lyr, col);
      end
      return column_report(RSP_OVERFLOW, MAX_LAYERS - 1, col);
   endfunction

   // ---------------- request driver ----------------
   span_req_type   req_backlog[$];
   col_result_type due_results[$];
   span_req_type   cur_req;
   int             n_queued = 0;
   int             n_accepted = 0;
   int             error_count = 0;
   int             req_gap = 0;
   int             rsp_stall = 0;
   bit             quiet = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            due_results.push_back(apply_request(cur_req));
            n_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               cur_req = req_backlog.pop_front();
               req_valid       <= 1'b1;
               req_action      <= cur_req.action;
               req_column      <= cur_req.column;
               req_span_top    <= cur_req.top;
               req_span_bottom <= cur_req.bottom;
               req_read_layer  <= cur_req.rlayer;
               if (!quiet && $urandom_range(0, 5) == 0)
                  req_gap = $urandom_range(1, 14);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- result monitor ----------------
   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      col_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result, expected none actual status %0d",
                        $time, rsp_status);
               error_count++;
            end else begin
               want = due_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("layer", want.layer, rsp_layer);
               check_field("out_top", want.top, rsp_out_top);
               check_field("out_bottom", want.bottom, rsp_out_bottom);
               check_field("range_min", want.rmin, rsp_range_min);
               check_field("range_max", want.rmax, rsp_range_max);
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
               rsp_stall = $urandom_range(1, 14);
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic push_req(action_type act, int col, int top, int bot, int lyr);
      span_req_type r;
      r.action = act;
      r.column = 10'(col);
      r.top    = 12'(top);
      r.bottom = 12'(bot);
      r.rlayer = 3'(lyr);
      req_backlog.push_back(r);
      n_queued++;
   endtask

   // every transfer accepted and every result back
   task automatic wait_idle();
      do @(posedge clock);
      while (n_queued != n_accepted || due_results.size() != 0);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [10:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_VIEW_WIDTH) cfg_view_width = data;
      else if (idx == CSR_VIEW_HEIGHT) cfg_view_height = data;
   endtask

   task automatic push_random(int hot_base);
      int sel, col, top, bot, vh;
      sel = $urandom_range(0, 99);
      vh  = cfg_view_height;
      col = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                         : hot_base + $urandom_range(0, 3);
      if (sel < 70) begin
         top = $urandom_range(0, vh) - 1;
         bot = top + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 400)
                                                  : $urandom_range(1, 12));
         if (bot > 2047) bot = 2047;
         push_req(ACT_ADD, col, top, bot, $urandom_range(0, 7));
      end else if (sel < 80) begin
         push_req(ACT_ADD, col, $urandom_range(0, 2048) - 1, $urandom_range(0, 2048) - 1,
                  $urandom_range(0, 7));
      end else if (sel < 92) begin
         push_req(ACT_READ, col, $urandom_range(0, 2048) - 1, $urandom_range(0, 2048) - 1,
                  $urandom_range(0, 7));
      end else if (sel < 96) begin
         push_req(ACT_NONE, col, $urandom_range(0, 2048) - 1, $urandom_range(0, 2048) - 1,
                  $urandom_range(0, 7));
      end else if ($urandom_range(0, 1) == 0) begin
         // off screen: bottom at or above row zero
         push_req(ACT_ADD, col, $urandom_range(0, 2048) - 1, $urandom_range(0, 1) - 1,
                  $urandom_range(0, 7));
      end else begin
         // off screen: top at or below the view height
         push_req(ACT_ADD, col, vh + $urandom_range(0, 2047 - vh),
                  $urandom_range(0, 2048) - 1, $urandom_range(0, 7));
      end
   endtask

   int phase_width  [6] = '{1, 1024, 40, 600, 5, 320};
   int phase_height [6] = '{1, 2047, 2047, 300, 1500, 200};
   bit phase_clear  [6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

   initial begin
      int hot_base;
      int clears_left;
      cfg_view_width  = 11'(RESET_VIEW_WIDTH);
      cfg_view_height = 11'(RESET_VIEW_HEIGHT);
      wipe_layers();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset view size
      push_req(ACT_READ, 0, 0, 0, 0);
      push_req(ACT_ADD, 5, 10, 20, 0);      // empty layer takes the span
      push_req(ACT_ADD, 5, 15, 30, 0);      // widens bottom
      push_req(ACT_ADD, 5, 5, 25, 0);       // widens top
      push_req(ACT_ADD, 5, 30, 40, 0);      // touching is disjoint: next layer
      push_req(ACT_ADD, 5, -1, 0, 0);       // bottom not below row zero
      push_req(ACT_ADD, 3, 200, 300, 0);    // top at view height
      push_req(ACT_ADD, 3, 199, 2047, 0);   // range grows downward
      push_req(ACT_ADD, 1023, -1, 2047, 0); // range grows upward
      push_req(ACT_ADD, 4, 50, 60, 0);      // empty column inside the range
      push_req(ACT_ADD, 4, 60, 50, 0);      // inverted span
      push_req(ACT_ADD, 4, 55, 58, 0);      // contained: no change
      for (int k = 0; k <= MAX_LAYERS; k++)
         push_req(ACT_ADD, 7, k * 10, k * 10 + 5, 0);  // last one overflows
      push_req(ACT_READ, 7, 0, 0, 7);
      push_req(ACT_READ, 4, 0, 0, 1);
      push_req(ACT_NONE, 1023, 2047, -1, 7);
      push_req(ACT_CLEAR, 5, 0, 0, 0);
      push_req(ACT_READ, 5, 0, 0, 1);
      wait_idle();

      clears_left = 4;
      for (int p = 0; p < 6; p++) begin
         if (p == 4) begin
            write_reg(CSR_SPARE_A, 11'($urandom_range(0, 2047)));
            write_reg(CSR_SPARE_B, 11'($urandom_range(0, 2047)));
         end
         write_reg(CSR_VIEW_WIDTH, 11'(phase_width[p]));
         write_reg(CSR_VIEW_HEIGHT, 11'(phase_height[p]));
         if (p == 5) quiet = 1'b1;
         if (phase_clear[p]) push_req(ACT_CLEAR, $urandom_range(0, 1023), 0, 0, 0);
         hot_base = $urandom_range(0, 1020);
         for (int i = 0; i < 67; i++) begin
            if (clears_left > 0 && $urandom_range(0, 99) == 0) begin
               push_req(ACT_CLEAR, $urandom_range(0, 1023), 0, 0, 0);
               clears_left--;
            end
            if (i == 33) begin
               wait_idle();  // sender holds off until all results are back
               hot_base = $urandom_range(0, 1020);
            end
            push_random(hot_base);
            // keep the backlog short so gaps land between transfers
            while (req_backlog.size() > 4) @(posedge clock);
         end
         wait_idle();
      end

      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
sv/lcsa_pkg.sv
sv/lcsa_ctrl.sv
sv/lcsa_datapath.sv
sv/layered_column_span_accumulator_core.sv
sim/tb_layered_column_span_accumulator_core.sv
